[design/lmdb_pkg.sv]
// ----------------------------------------------------------------------------
// lmdb_pkg
// shared types and constants for the double-buffered led matrix row scanner
// ----------------------------------------------------------------------------
package lmdb_pkg;

    localparam int ROWS          = 6;
    localparam int BYTES_PER_ROW = 8;
    localparam int FRAME_BYTES   = ROWS * BYTES_PER_ROW;
    localparam int WORDS         = 2 * ROWS;
    localparam int ROW_W         = 3;
    localparam int COL_W         = 3;
    localparam int FILL_W        = 6;
    localparam int WORD_AW       = 4;
    localparam int PIXEL_W       = 8;
    localparam int SHIFT_W       = 64;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [PIXEL_W-1:0] pixel_byte;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]   row_off;
        logic [ROW_W-1:0]   row_on;
        logic [SHIFT_W-1:0] shift_word;
    } t_out_item;

endpackage

[design/lmdb_in_stage.sv]
// ----------------------------------------------------------------------------
// lmdb_in_stage
// input register holding one item until the scan core takes it
// ----------------------------------------------------------------------------
module lmdb_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lmdb_pkg::t_in_item i_item,
    input  logic              i_take,
    output logic              o_valid,
    output lmdb_pkg::t_in_item o_item
);
    import lmdb_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     n_valid;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

[design/lmdb_scan_core.sv]
// ----------------------------------------------------------------------------
// lmdb_scan_core
// frame store, fill position, shown frame and scan row; one item per step
// ----------------------------------------------------------------------------
module lmdb_scan_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  lmdb_pkg::t_in_item  i_item,
    output lmdb_pkg::t_out_item o_result
);
    import lmdb_pkg::*;

    localparam logic [FILL_W-1:0]  LAST_FILL = FILL_W'(FRAME_BYTES - 1);
    localparam logic [ROW_W-1:0]   LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]   LAST_COL  = COL_W'(BYTES_PER_ROW - 1);
    localparam logic [WORD_AW-1:0] ROWS_BASE = WORD_AW'(ROWS);

    logic [SHIFT_W-1:0] r_frame [WORDS];
    logic               r_shown;
    logic [FILL_W-1:0]  r_fill;
    logic [ROW_W-1:0]   r_scan;

    logic               n_shown;
    logic [FILL_W-1:0]  n_fill;
    logic [ROW_W-1:0]   n_scan;

    logic [ROW_W-1:0]   fill_row;
    logic [COL_W-1:0]   lane;
    logic [WORD_AW-1:0] wr_idx;
    logic [WORD_AW-1:0] rd_idx;
    logic [ROW_W-1:0]   next_row;
    logic               do_pixel;
    logic               do_tick;

    assign do_pixel = i_step && (i_item.operation == OP_PIXEL);
    assign do_tick  = i_step && (i_item.operation == OP_TICK);

    always_comb begin
        fill_row = r_fill[FILL_W-1:COL_W];
        lane     = LAST_COL - r_fill[COL_W-1:0];
        wr_idx   = (r_shown ? '0 : ROWS_BASE) + WORD_AW'(fill_row);
        next_row = (r_scan == LAST_ROW) ? '0 : r_scan + 1'b1;
        rd_idx   = (r_shown ? ROWS_BASE : '0) + WORD_AW'(next_row);

        n_shown = r_shown;
        n_fill  = r_fill;
        n_scan  = r_scan;
        if (do_pixel) begin
            if (r_fill == LAST_FILL) begin
                n_fill  = '0;
                n_shown = !r_shown;
            end else begin
                n_fill = r_fill + 1'b1;
            end
        end
        if (do_tick) begin
            n_scan = next_row;
        end

        o_result.row_off    = (r_scan == '0) ? LAST_ROW : r_scan - 1'b1;
        o_result.row_on     = r_scan;
        o_result.shift_word = r_frame[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown <= 1'b0;
            r_fill  <= '0;
            r_scan  <= '0;
        end else begin
            r_shown <= n_shown;
            r_fill  <= n_fill;
            r_scan  <= n_scan;
        end
    end

    // both frames start blank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < WORDS; w++) begin
                r_frame[w] <= '0;
            end
        end else if (do_pixel) begin
            r_frame[wr_idx][{lane, 3'b000} +: PIXEL_W] <= i_item.pixel_byte;
        end
    end

endmodule

[design/lmdb_out_stage.sv]
// ----------------------------------------------------------------------------
// lmdb_out_stage
// result register that holds one item until the consumer takes it
// ----------------------------------------------------------------------------
module lmdb_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  lmdb_pkg::t_out_item i_item,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output lmdb_pkg::t_out_item o_item
);
    import lmdb_pkg::*;

    logic      r_valid;
    t_out_item r_item;
    logic      n_valid;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_item <= i_item;
        end
    end

endmodule

[design/led_matrix_double_buffer_row_scan_top.sv]
// ----------------------------------------------------------------------------
// led_matrix_double_buffer_row_scan_top
// double-buffered row scanner for a 6 x 64 multiplexed led matrix
// ----------------------------------------------------------------------------
// Each input item is either a pixel byte, written row-major into the frame
// not being shown, or a refresh tick, which returns the row to switch off,
// the row to switch on and the next row of the shown frame as a 64-bit shift
// word (bit 63 first). Pixel bytes give no result. An item passes an input
// register, the update logic on the frame store and a result register, and
// one item is taken every cycle while the result register is free or being
// drained. Both frames are blank after reset, with no clearing pass.
module led_matrix_double_buffer_row_scan_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lmdb_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lmdb_pkg::t_out_item o_out_item
);
    import lmdb_pkg::*;

    logic      s1_valid;
    t_in_item  s1_item;
    logic      s1_take;
    logic      out_free;
    logic      is_tick;
    t_out_item core_result;

    assign is_tick = s1_item.operation == OP_TICK;
    assign s1_take = s1_valid && (!is_tick || out_free);

    lmdb_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .i_take  (s1_take),
        .o_valid (s1_valid),
        .o_item  (s1_item)
    );

    lmdb_scan_core u_scan_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_take),
        .i_item   (s1_item),
        .o_result (core_result)
    );

    lmdb_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_take && is_tick),
        .i_item  (core_result),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

[sim/led_scan_monitor.sv]
// ----------------------------------------------------------------------------
// led_scan_monitor
// watches both item channels of the row scanner, predicts every refresh
// result from its own copy of the frame store and compares field by field
// ----------------------------------------------------------------------------
module led_scan_monitor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  lmdb_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  lmdb_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lmdb_pkg::*;

    logic [SHIFT_W-1:0] frame_words [WORDS];
    logic               view_frame;
    logic [FILL_W-1:0]  fill_slot;
    logic [ROW_W-1:0]   lit_row;
    t_out_item          scan_results_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic store_pixel(input logic [PIXEL_W-1:0] value);
        int row;
        int col;
        int word;
        row  = fill_slot / BYTES_PER_ROW;
        col  = fill_slot % BYTES_PER_ROW;
        word = (view_frame ? 0 : ROWS) + row;
        // bytes land in serial order: row byte 0 ends up in the top byte
        frame_words[word][PIXEL_W*(BYTES_PER_ROW-1-col) +: PIXEL_W] = value;
        if (fill_slot == FRAME_BYTES - 1) begin
            fill_slot  = '0;
            view_frame = ~view_frame;
        end else begin
            fill_slot++;
        end
    endtask

    task automatic advance_scan(output t_out_item res);
        res.row_off = (lit_row == 0) ? ROW_W'(ROWS - 1) : ROW_W'(lit_row - 1);
        res.row_on  = lit_row;
        lit_row     = (lit_row == ROWS - 1) ? '0 : ROW_W'(lit_row + 1);
        res.shift_word = frame_words[(view_frame ? ROWS : 0) + lit_row];
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item res;
        if (!i_rst_n) begin
            foreach (frame_words[w]) begin
                frame_words[w] = '0;
            end
            view_frame = 1'b0;
            fill_slot  = '0;
            lit_row    = '0;
            scan_results_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (scan_results_q.size() == 0) begin
                    report_mismatch($sformatf("result with none expected: %h", i_out_item));
                end else begin
                    want = scan_results_q.pop_front();
                    if (i_out_item.row_off !== want.row_off) begin
                        report_mismatch($sformatf("row_off %0d, expected %0d",
                                                  i_out_item.row_off, want.row_off));
                    end
                    if (i_out_item.row_on !== want.row_on) begin
                        report_mismatch($sformatf("row_on %0d, expected %0d",
                                                  i_out_item.row_on, want.row_on));
                    end
                    if (i_out_item.shift_word !== want.shift_word) begin
                        report_mismatch($sformatf("shift_word %h, expected %h",
                                                  i_out_item.shift_word, want.shift_word));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_item.operation == OP_PIXEL) begin
                    store_pixel(i_in_item.pixel_byte);
                end else begin
                    advance_scan(res);
                    scan_results_q.push_back(res);
                end
            end
        end
        o_pending = scan_results_q.size();
    end

endmodule

[sim/tb_led_matrix_double_buffer_row_scan_top.sv]
// ----------------------------------------------------------------------------
// tb_led_matrix_double_buffer_row_scan_top
// drives pixel bytes and refresh ticks into the row scanner with bursty
// input and a stalling receiver, and reports the verdict of the monitor
// ----------------------------------------------------------------------------
module tb_led_matrix_double_buffer_row_scan_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 8;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    lmdb_pkg::t_in_item  i_in_item;
    logic                o_out_valid;
    logic                i_out_ready;
    lmdb_pkg::t_out_item o_out_item;

    int fail_count;
    int pending_results;
    bit hold_request;
    int burst_left;

    led_matrix_double_buffer_row_scan_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    led_scan_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_item   (o_out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb_led_matrix_double_buffer_row_scan_top failed");
        $finish;
    end

    // receiver: duty pattern that changes at random intervals, plus long hold-offs
    initial begin
        int period;
        int duty;
        int phase_cnt;
        int left;
        left        = 0;
        period      = 1;
        duty        = 1;
        phase_cnt   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (left == 0) begin
                period    = $urandom_range(1, 8);
                duty      = $urandom_range(1, period);
                left      = $urandom_range(16, 96);
                phase_cnt = 0;
            end
            i_out_ready <= (phase_cnt % period) < duty;
            phase_cnt++;
            left--;
        end
    end

    function automatic lmdb_pkg::t_in_item tick_item();
        lmdb_pkg::t_in_item item;
        item.operation  = lmdb_pkg::OP_TICK;
        item.pixel_byte = 8'($urandom_range(0, 255));
        return item;
    endfunction

    function automatic lmdb_pkg::t_in_item pixel_item(input logic [7:0] value);
        lmdb_pkg::t_in_item item;
        item.operation  = lmdb_pkg::OP_PIXEL;
        item.pixel_byte = value;
        return item;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input lmdb_pkg::t_in_item item);
        int gap;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 48);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [7:0] edge_bytes [8];
        int         sent;
        int         seg;
        int         seg_len;
        int         tick_pct;
        logic [7:0] value;
        edge_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE};
        hold_request = 1'b0;
        burst_left   = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_item    = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // blank frames, scan row wraps past the last row
        repeat (7) send_item(tick_item());
        foreach (edge_bytes[k]) begin
            send_item(pixel_item(edge_bytes[k]));
        end
        repeat (3) send_item(tick_item());
        wait_results_drained();

        sent = 0;
        seg  = 0;
        while (sent < RANDOM_ITEMS) begin
            if (seg == 0) begin
                // tick-heavy item stream against a stopped receiver
                hold_request = 1'b1;
                tick_pct     = 80;
                seg_len      = 60;
            end else begin
                case ($urandom_range(0, 2))
                    0:       tick_pct = 10;
                    1:       tick_pct = 40;
                    default: tick_pct = 80;
                endcase
                seg_len = $urandom_range(20, 80);
            end
            repeat (seg_len) begin
                if ($urandom_range(0, 99) < tick_pct) begin
                    send_item(tick_item());
                end else begin
                    case ($urandom_range(0, 9))
                        0:       value = 8'h00;
                        1:       value = 8'hFF;
                        default: value = 8'($urandom_range(0, 255));
                    endcase
                    send_item(pixel_item(value));
                end
            end
            sent += seg_len;
            seg++;
            if (seg == 6) begin
                wait_results_drained();
                hold_request = 1'b1;
            end
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb_led_matrix_double_buffer_row_scan_top passed");
        end else begin
            $display("tb_led_matrix_double_buffer_row_scan_top failed");
        end
        $finish;
    end

endmodule
